// ===== hw/rtl/fbff_pkg.sv =====
package fbff_pkg;
	localparam int ROWS = 32;
	localparam int COLS = 64;
	localparam int COLOR_BITS = 4;
	localparam int PIXELS = ROWS * COLS;
	localparam int RW = 5;
	localparam int CW = 6;
	localparam int AW = $clog2(PIXELS);
	localparam int DW = AW + 1;

	localparam logic [2:0] CMD_WRITE  = 3'd0;
	localparam logic [2:0] CMD_SETON  = 3'd1;
	localparam logic [2:0] CMD_READ   = 3'd2;
	localparam logic [2:0] CMD_FLIP   = 3'd3;
	localparam logic [2:0] CMD_REPNT  = 3'd4;
	localparam logic [2:0] CMD_FILL   = 3'd5;

	typedef struct packed {
		logic [2:0]  command;
		logic [RW-1:0] row;
		logic [CW-1:0] col;
		logic [3:0]  new_color;
		logic [3:0]  match_color;
		logic        on_value;
	} cmd_t;

	typedef struct packed {
		logic [2:0]      command;
		logic            bad;
		logic [AW-1:0]   idx;
		logic [COLOR_BITS-1:0] nc;
		logic [COLOR_BITS-1:0] mc;
		logic            onv;
	} op_t;

	typedef struct packed {
		logic [3:0] pixel_color;
		logic       pixel_on;
		logic       status;
	} res_t;
endpackage

// ===== hw/rtl/fbff_stream_if.sv =====
interface fbff_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/fbff_ram.sv =====
module fbff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/fbff_front.sv =====
module fbff_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  fbff_pkg::cmd_t in_cmd,
	output logic q_valid,
	input  logic q_ready,
	output fbff_pkg::op_t q_op
);
	import fbff_pkg::*;
	localparam int QD = 2;
	op_t buf_q [QD];
	logic [0:0] wp_q, rp_q;
	logic [1:0] cnt_q;
	op_t op;
	logic push, pop, in_range;

	always_comb begin
		in_range = (32'(in_cmd.row) < ROWS) && (32'(in_cmd.col) < COLS);
		op.command = in_cmd.command;
		op.bad = !in_range && (in_cmd.command == CMD_WRITE || in_cmd.command == CMD_SETON
			|| in_cmd.command == CMD_READ || in_cmd.command == CMD_FILL);
		op.idx = in_range ? AW'(32'(in_cmd.row) * COLS + 32'(in_cmd.col)) : '0;
		op.nc = in_cmd.new_color[COLOR_BITS-1:0];
		op.mc = in_cmd.match_color[COLOR_BITS-1:0];
		op.onv = in_cmd.on_value;
	end

	assign in_ready = cnt_q != 2'(QD);
	assign q_valid = cnt_q != 2'd0;
	assign q_op = buf_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== hw/rtl/fbff_back.sv =====
module fbff_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  fbff_pkg::op_t q_op,
	output logic out_valid,
	input  logic out_ready,
	output fbff_pkg::res_t out_res
);
	import fbff_pkg::*;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_READ  = 4'd2;
	localparam logic [3:0] S_SWRD  = 4'd3;
	localparam logic [3:0] S_SWWR  = 4'd4;
	localparam logic [3:0] S_FSRD  = 4'd5;
	localparam logic [3:0] S_FSCHK = 4'd6;
	localparam logic [3:0] S_POP   = 4'd7;
	localparam logic [3:0] S_POPW  = 4'd8;
	localparam logic [3:0] S_NRD   = 4'd9;
	localparam logic [3:0] S_NCHK  = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0] st_q;
	op_t op_q;
	logic [AW-1:0] ptr_q;
	logic [DW-1:0] sp_q;
	logic [COLOR_BITS-1:0] old_q;
	logic [RW-1:0] pr_q;
	logic [CW-1:0] pc_q;
	logic [2:0] dir_q;
	logic [AW-1:0] nidx_q;
	res_t res_q;
	logic ov_q;

	logic c_we, o_we, s_we;
	logic [AW-1:0] c_wa, c_ra, o_wa, o_ra, s_wa, s_ra;
	logic [COLOR_BITS-1:0] c_wd, c_rd;
	logic o_wd, o_rd;
	logic [AW-1:0] s_wd, s_rd;

	fbff_ram #(.WIDTH(COLOR_BITS), .DEPTH(PIXELS)) u_color (
		.clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
	fbff_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_on (
		.clk, .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
	fbff_ram #(.WIDTH(AW), .DEPTH(PIXELS)) u_stack (
		.clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

	// neighbour candidate for direction dir_q: up, down, right, left
	logic nvalid;
	logic [AW-1:0] ncand;
	always_comb begin
		nvalid = 1'b0;
		ncand = '0;
		case (dir_q)
			3'd0: begin
				nvalid = pr_q != '0;
				ncand = AW'(32'(pr_q - 1'b1) * COLS + 32'(pc_q));
			end
			3'd1: begin
				nvalid = 32'(pr_q) + 1 < ROWS;
				ncand = AW'((32'(pr_q) + 1) * COLS + 32'(pc_q));
			end
			3'd2: begin
				nvalid = 32'(pc_q) + 1 < COLS;
				ncand = AW'(32'(pr_q) * COLS + 32'(pc_q) + 1);
			end
			3'd3: begin
				nvalid = pc_q != '0;
				ncand = AW'(32'(pr_q) * COLS + 32'(pc_q) - 1);
			end
			default: begin
				nvalid = 1'b0;
				ncand = '0;
			end
		endcase
	end

	assign q_ready = (st_q == S_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign out_res = res_q;

	always_comb begin
		c_we = 1'b0; c_wa = ptr_q; c_wd = op_q.nc; c_ra = ptr_q;
		o_we = 1'b0; o_wa = ptr_q; o_wd = 1'b0; o_ra = ptr_q;
		s_we = 1'b0; s_wa = sp_q[AW-1:0]; s_wd = nidx_q; s_ra = sp_q[AW-1:0] - 1'b1;
		case (st_q)
			S_CLEAR: begin
				c_we = 1'b1; c_wd = '0; o_we = 1'b1; o_wd = 1'b0;
			end
			S_IDLE: begin
				c_ra = q_op.idx; o_ra = q_op.idx; c_wa = q_op.idx; o_wa = q_op.idx;
				c_wd = q_op.nc; o_wd = q_op.onv;
				if (q_valid && q_ready && !q_op.bad) begin
					c_we = q_op.command == CMD_WRITE;
					o_we = q_op.command == CMD_SETON;
				end
			end
			S_SWWR: begin
				o_we = op_q.command == CMD_FLIP; o_wd = !o_rd;
				c_we = op_q.command == CMD_REPNT && c_rd == op_q.mc;
			end
			S_FSCHK: begin
				c_we = c_rd != op_q.nc; s_we = c_rd != op_q.nc;
				s_wd = ptr_q; s_wa = '0;
			end
			S_NRD: c_ra = ncand;
			S_NCHK: begin
				c_wa = nidx_q;
				c_we = c_rd == old_q && 32'(sp_q) < PIXELS;
				s_we = c_we;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) op_q <= q_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR; ptr_q <= '0; sp_q <= '0; ov_q <= 1'b0;
			res_q <= '0; old_q <= '0; pr_q <= '0; pc_q <= '0; dir_q <= '0; nidx_q <= '0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (st_q)
				S_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (32'(ptr_q) == PIXELS - 1) st_q <= S_IDLE;
				end
				S_IDLE: if (q_valid && q_ready) begin
					res_q <= '{pixel_color: 4'd0, pixel_on: 1'b0, status: q_op.bad};
					ptr_q <= (q_op.command == CMD_FLIP || q_op.command == CMD_REPNT)
						? '0 : q_op.idx;
					if (q_op.bad) begin
						ov_q <= 1'b1;
					end else if (q_op.command == CMD_READ) st_q <= S_READ;
					else if (q_op.command == CMD_FLIP || q_op.command == CMD_REPNT) begin
						st_q <= S_SWRD;
					end else if (q_op.command == CMD_FILL) st_q <= S_FSRD;
					else ov_q <= 1'b1;
				end
				S_READ: begin
					res_q <= '{pixel_color: 4'(c_rd), pixel_on: o_rd, status: 1'b0};
					ov_q <= 1'b1; st_q <= S_IDLE;
				end
				S_SWRD: st_q <= S_SWWR;
				S_SWWR: begin
					ptr_q <= ptr_q + 1'b1;
					if (32'(ptr_q) == PIXELS - 1) begin
						ov_q <= 1'b1; st_q <= S_IDLE;
					end else st_q <= S_SWRD;
				end
				S_FSRD: st_q <= S_FSCHK;
				S_FSCHK: begin
					old_q <= c_rd;
					if (c_rd == op_q.nc) begin
						ov_q <= 1'b1; st_q <= S_IDLE;
					end else begin
						sp_q <= DW'(1); st_q <= S_POP;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						ov_q <= 1'b1; st_q <= S_IDLE;
					end else st_q <= S_POPW;
				end
				S_POPW: begin
					sp_q <= sp_q - 1'b1;
					pr_q <= RW'(32'(s_rd) / COLS);
					pc_q <= CW'(32'(s_rd) % COLS);
					dir_q <= '0;
					st_q <= S_NRD;
					nidx_q <= '0;
				end
				S_NRD: begin
					if (dir_q == 3'd4) st_q <= S_POP;
					else if (nvalid) begin
						nidx_q <= ncand; st_q <= S_NCHK;
					end else dir_q <= dir_q + 1'b1;
				end
				S_NCHK: begin
					if (c_we) sp_q <= sp_q + 1'b1;
					dir_q <= dir_q + 1'b1;
					st_q <= S_NRD;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/frame_buffer_flood_fill.sv =====
// Channel | Dir | Payload
// cmd_in  | in  | command, row, col, new_color, match_color, on_value
// res_out | out | pixel_color, pixel_on, status
//
// Write, set-on and out-of-range commands answer once accepted; a read first passes a read state.
// Flip and repaint visit every pixel with a read state and a write state each; a fill
// reads the seed, then pops the stack and probes each in-frame neighbour in turn,
// skipping frame edges, paced by the single colour store port pair.
// After reset the store is cleared pixel by pixel before the back end takes any item.
// A two-entry queue decouples command intake from execution; a stalled result
// holds the back end but the queue keeps accepting until it holds two items.
module frame_buffer_flood_fill (
	input logic clk,
	input logic arst_n,
	fbff_stream_if.sink   cmd_in,
	fbff_stream_if.source res_out
);
	import fbff_pkg::*;

	// Queue between the classifying front end and the executing back end.
	logic q_valid, q_ready;
	op_t q_op;
	res_t res;

	fbff_front u_front (
		.clk, .arst_n,
		.in_valid(cmd_in.valid), .in_ready(cmd_in.ready), .in_cmd(cmd_t'(cmd_in.data)),
		.q_valid, .q_ready, .q_op
	);

	fbff_back u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_op,
		.out_valid(res_out.valid), .out_ready(res_out.ready), .out_res(res)
	);

	assign res_out.data = res;
endmodule

// ===== hw/rtl/fbff_checker.sv =====
module fbff_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [5:0] out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
	a_rst: assert property (@(posedge clk) !arst_n |-> !out_valid) else $error("valid in reset");
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data[0] |-> out_data[5:1] == 5'd0) else $error("bad status");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_valid, in_ready, out_valid})) else $error("unknown handshake");
endmodule

bind frame_buffer_flood_fill fbff_checker u_chk (
	.clk, .arst_n,
	.in_valid(cmd_in.valid), .in_ready(cmd_in.ready),
	.out_valid(res_out.valid), .out_ready(res_out.ready), .out_data(res_out.data)
);
